FILE: hdl/lfs_pkg.sv
// Shared types and constants for the line-follow PD steering unit.
// No dependencies; used by lfs_ctrl, lfs_dp and the top level.
package lfs_pkg;

   // Configuration register indexes and port widths
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_FAST = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_SLOW = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_MIN  = 3'd4;

   // Register reset values
   localparam logic [11:0] PROP_GAIN_RST  = 12'd1536;
   localparam logic [11:0] DERIV_GAIN_RST = 12'd896;
   localparam logic [6:0]  SPEED_FAST_RST = 7'd45;
   localparam logic [6:0]  SPEED_SLOW_RST = 7'd25;
   localparam logic [6:0]  SPEED_MIN_RST  = 7'd4;

   // Error divider: one quotient bit per step over a 12-bit dividend
   localparam int DIV_STEPS = 12;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Sensor weights, left half and right half
   localparam logic [3:0] WEIGHT_L [4] = '{4'd6, 4'd4, 4'd2, 4'd0};
   localparam logic [3:0] WEIGHT_R [4] = '{4'd0, 4'd2, 4'd4, 4'd6};

   // Track state codes
   localparam logic [3:0] TRACK_GO      = 4'd0;
   localparam logic [3:0] TRACK_RIGHT1  = 4'd1;
   localparam logic [3:0] TRACK_RIGHT2  = 4'd2;
   localparam logic [3:0] TRACK_RIGHT3  = 4'd3;
   localparam logic [3:0] TRACK_LEFT1   = 4'd4;
   localparam logic [3:0] TRACK_LEFT2   = 4'd5;
   localparam logic [3:0] TRACK_LEFT3   = 4'd6;
   localparam logic [3:0] TRACK_LOST    = 4'd7;
   localparam logic [3:0] TRACK_CROSS   = 4'd8;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic div_step;
      logic resolve;
      logic mul_p;
      logic mul_d;
      logic base;
      logic wheel;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic spin;
      logic out_free;
   } status_type;

endpackage

FILE: hdl/lfs_ctrl.sv
// Sequencer for the line-follow steering unit.
// Depends on lfs_pkg; drives the lfs_dp command struct.
module lfs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  lfs_pkg::status_type status,
   output lfs_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DIV     = 3'd1;
   localparam logic [2:0] S_RESOLVE = 3'd2;
   localparam logic [2:0] S_MULP    = 3'd3;
   localparam logic [2:0] S_MULD    = 3'd4;
   localparam logic [2:0] S_BASE    = 3'd5;
   localparam logic [2:0] S_WHEEL   = 3'd6;

   localparam logic [lfs_pkg::DIV_CNT_W-1:0] DIV_LAST =
      lfs_pkg::DIV_CNT_W'(lfs_pkg::DIV_STEPS - 1);

   logic [2:0]                    state_ff, state_in;
   logic [lfs_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load   = 1'b1;
               div_cnt_in = '0;
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in = S_RESOLVE;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         S_RESOLVE: begin
            cmd.resolve = 1'b1;
            state_in    = status.spin ? S_WHEEL : S_MULP;
         end
         S_MULP: begin
            cmd.mul_p = 1'b1;
            state_in  = S_MULD;
         end
         S_MULD: begin
            cmd.mul_d = 1'b1;
            state_in  = S_BASE;
         end
         S_BASE: begin
            cmd.base = 1'b1;
            state_in = S_WHEEL;
         end
         S_WHEEL: begin
            // hold here while the output register is still occupied
            if (status.out_free) begin
               cmd.wheel = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   // Checks
   a_load_starts_div: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == S_DIV))
      else $error("load did not start the divider");

   a_div_full_length: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == S_DIV && state_ff != S_DIV) |-> ($past(div_cnt_ff) == DIV_LAST))
      else $error("divider left early");

   a_wheel_returns_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.wheel |=> req_ready)
      else $error("not idle after result load");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one command at once");

endmodule

FILE: hdl/lfs_dp.sv
// Datapath for the line-follow steering unit: registers, error divider,
// PD multipliers, speed shaping and the output register. Depends on lfs_pkg.
module lfs_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  lfs_pkg::cmd_type                 cmd,
   output lfs_pkg::status_type              status,
   input  logic [7:0]                       req_sensor_bits,
   input  logic                             csr_valid,
   input  logic [lfs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lfs_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [8:0]                rsp_left_speed,
   output logic signed [8:0]                rsp_right_speed,
   output logic [3:0]                       rsp_track_state
);

   localparam logic [11:0] MAG_GO  = 12'd128;
   localparam logic [11:0] MAG_LV1 = 12'd512;
   localparam logic [11:0] MAG_LV2 = 12'd1024;
   localparam logic [12:0] SPEED_SPAN = 13'd5120;
   localparam logic [17:0] RECIP_5 = 18'd205;
   localparam logic signed [26:0] STEER_LIM = 27'sd2293760;  // 35 in Q.16
   localparam logic signed [8:0]  STEER_WHEEL = 9'sd35;

   // Configuration registers
   logic [11:0] prop_gain_ff, deriv_gain_ff;
   logic [6:0]  speed_fast_ff, speed_slow_ff, speed_min_ff;

   // Track state
   logic              line_seen_ff;
   logic signed [11:0] held_ff, prev_ff;

   // Per-transaction working registers
   logic               num_neg_ff, lost_ff, cross_ff, spin_ff;
   logic [2:0]         cnt_ff, rem_ff;
   logic [11:0]        quo_ff;
   logic signed [11:0] err_ff;
   logic [3:0]         code_ff;
   logic signed [24:0] prod_p_ff, steer_c_ff;
   logic signed [26:0] steer_ff;
   logic [19:0]        base_prod_ff;
   logic [6:0]         base_ff;

   // Output register
   logic               rsp_valid_ff;
   logic signed [8:0]  left_ff, right_ff;
   logic [3:0]         track_ff;

   // Combinational values
   logic [3:0]         sum_l, sum_r, cnt_all, num_mag_in;
   logic [3:0]         rem_try;
   logic [2:0]         rem_in;
   logic               quo_bit;
   logic signed [11:0] err_div, err_sel;
   logic [3:0]         code_in;
   logic [12:0]        err_abs;
   logic signed [12:0] err_diff;
   logic signed [25:0] prod_d;
   logic signed [26:0] steer_in, steer_cl;
   logic [17:0]        base_q;
   logic [6:0]         base_raw;
   logic signed [24:0] v_left, v_right;
   logic signed [8:0]  wheel_lo, wheel_hi, left_in, right_in;

   // Truncate a Q.16 value toward zero
   function automatic logic signed [8:0] trunc_q16(input logic signed [24:0] v);
      logic signed [24:0] a;
      a = v[24] ? (v + 25'sd65535) : v;
      return a[24:16];
   endfunction

   // Raise to the low bound, then lower to the high bound
   function automatic logic signed [8:0] clamp_wheel(input logic signed [8:0] v,
                                                     input logic signed [8:0] lo,
                                                     input logic signed [8:0] hi);
      logic signed [8:0] r;
      r = v;
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r;
   endfunction

   // Weighted sums and set-bit count of the sample
   always_comb begin
      sum_l   = '0;
      sum_r   = '0;
      cnt_all = '0;
      for (int i = 0; i < 4; i++) begin
         if (req_sensor_bits[i]) sum_l = sum_l + lfs_pkg::WEIGHT_L[i];
         if (req_sensor_bits[i+4]) sum_r = sum_r + lfs_pkg::WEIGHT_R[i];
         cnt_all = cnt_all + {3'b0, req_sensor_bits[i]} + {3'b0, req_sensor_bits[i+4]};
      end
      num_mag_in = (sum_l >= sum_r) ? (sum_l - sum_r) : (sum_r - sum_l);
   end

   // One restoring division step
   always_comb begin
      rem_try = {rem_ff, quo_ff[11]};
      if (rem_try >= {1'b0, cnt_ff}) begin
         rem_in  = 3'(rem_try - {1'b0, cnt_ff});
         quo_bit = 1'b1;
      end else begin
         rem_in  = rem_try[2:0];
         quo_bit = 1'b0;
      end
   end

   // Error selection and track code
   always_comb begin
      err_div = num_neg_ff ? (12'sd0 - $signed(quo_ff)) : $signed(quo_ff);
      if (lost_ff) begin
         err_sel = held_ff;
         code_in = lfs_pkg::TRACK_LOST;
      end else if (cross_ff) begin
         err_sel = '0;
         code_in = lfs_pkg::TRACK_CROSS;
      end else begin
         err_sel = err_div;
         if (quo_ff < MAG_GO) begin
            code_in = lfs_pkg::TRACK_GO;
         end else if (quo_ff < MAG_LV1) begin
            code_in = num_neg_ff ? lfs_pkg::TRACK_LEFT1 : lfs_pkg::TRACK_RIGHT1;
         end else if (quo_ff < MAG_LV2) begin
            code_in = num_neg_ff ? lfs_pkg::TRACK_LEFT2 : lfs_pkg::TRACK_RIGHT2;
         end else begin
            code_in = num_neg_ff ? lfs_pkg::TRACK_LEFT3 : lfs_pkg::TRACK_RIGHT3;
         end
      end
   end

   // PD products, base speed and wheel speeds
   always_comb begin
      err_abs  = err_ff[11] ? (13'd0 - {err_ff[11], err_ff}) : {1'b0, err_ff};
      err_diff = $signed({err_ff[11], err_ff}) - $signed({prev_ff[11], prev_ff});
      prod_d   = $signed({1'b0, deriv_gain_ff}) * err_diff;
      steer_in = $signed({{2{prod_p_ff[24]}}, prod_p_ff}) + $signed({prod_d[25], prod_d});
      if (steer_ff > STEER_LIM) begin
         steer_cl = STEER_LIM;
      end else if (steer_ff < -STEER_LIM) begin
         steer_cl = -STEER_LIM;
      end else begin
         steer_cl = steer_ff;
      end
      // divide by 5120: drop 10 bits, then times 205 over 1024 is exact below 1024
      base_q   = {8'b0, base_prod_ff[19:10]} * RECIP_5;
      base_raw = base_q[16:10];
      v_left   = $signed({2'b0, base_ff, 16'b0}) - steer_c_ff;
      v_right  = $signed({2'b0, base_ff, 16'b0}) + steer_c_ff;
      wheel_lo = $signed({2'b0, speed_min_ff});
      wheel_hi = $signed({2'b0, speed_fast_ff}) + STEER_WHEEL;
      if (spin_ff) begin
         left_in  = 9'sd0 - $signed({2'b0, speed_slow_ff});
         right_in = $signed({2'b0, speed_slow_ff});
      end else begin
         left_in  = clamp_wheel(trunc_q16(v_left), wheel_lo, wheel_hi);
         right_in = clamp_wheel(trunc_q16(v_right), wheel_lo, wheel_hi);
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= lfs_pkg::PROP_GAIN_RST;
         deriv_gain_ff <= lfs_pkg::DERIV_GAIN_RST;
         speed_fast_ff <= lfs_pkg::SPEED_FAST_RST;
         speed_slow_ff <= lfs_pkg::SPEED_SLOW_RST;
         speed_min_ff  <= lfs_pkg::SPEED_MIN_RST;
      end else if (csr_valid) begin
         case (csr_index)
            lfs_pkg::CSR_PROP_GAIN:  prop_gain_ff  <= csr_data;
            lfs_pkg::CSR_DERIV_GAIN: deriv_gain_ff <= csr_data;
            lfs_pkg::CSR_SPEED_FAST: speed_fast_ff <= csr_data[6:0];
            lfs_pkg::CSR_SPEED_SLOW: speed_slow_ff <= csr_data[6:0];
            lfs_pkg::CSR_SPEED_MIN:  speed_min_ff  <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // Track memory across samples
   always_ff @(posedge clock) begin
      if (reset) begin
         line_seen_ff <= 1'b0;
         held_ff      <= '0;
         prev_ff      <= '0;
      end else begin
         if (cmd.resolve) begin
            line_seen_ff <= line_seen_ff | ~lost_ff;
            if (!lost_ff) held_ff <= err_sel;
         end
         if (cmd.mul_d) prev_ff <= err_ff;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         num_neg_ff <= (sum_l < sum_r);
         cnt_ff     <= cnt_all[2:0];
         lost_ff    <= (req_sensor_bits == 8'h00);
         cross_ff   <= (req_sensor_bits == 8'hFF);
         rem_ff     <= '0;
         quo_ff     <= {num_mag_in, 8'b0};
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[10:0], quo_bit};
      end
      if (cmd.resolve) begin
         err_ff  <= err_sel;
         code_ff <= code_in;
         spin_ff <= lost_ff & ~line_seen_ff;
      end
      if (cmd.mul_p) begin
         prod_p_ff    <= $signed({1'b0, prop_gain_ff}) * err_ff;
         base_prod_ff <= {13'b0, speed_fast_ff} * {7'b0, SPEED_SPAN - err_abs};
      end
      if (cmd.mul_d) steer_ff <= steer_in;
      if (cmd.base) begin
         steer_c_ff <= steer_cl[24:0];
         base_ff    <= (base_raw < speed_min_ff) ? speed_min_ff : base_raw;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.wheel) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wheel) begin
         left_ff  <= left_in;
         right_ff <= right_in;
         track_ff <= code_ff;
      end
   end

   assign status.spin     = lost_ff & ~line_seen_ff;
   assign status.out_free = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_speed  = left_ff;
   assign rsp_right_speed = right_ff;
   assign rsp_track_state = track_ff;

endmodule

FILE: hdl/line_follow_pd_steering_unit.sv
// Line-follow PD steering unit: sensor sample in, wheel speeds and state out.
// Depends on lfs_pkg, lfs_ctrl and lfs_dp.
//
// Channels: req_ carries one 8-bit sensor sample per transaction (black = 1).
// rsp_ returns one transaction per sample: left and right wheel speeds
// (9-bit two's complement) and a track state code. csr_ writes the gain and
// speed registers by index; csr_ready is always high, writes to unused
// indexes are dropped. Write configuration only while the unit is idle.
//
// Steps from request to response valid: accept, 12 divider steps, error
// resolve, two multiply steps, base speed, wheel load. The error division
// by the set-bit count takes one quotient bit per cycle and is the longest
// step. A spin sample (all white before the line was ever seen) skips the
// multiply and base steps. One sample is in work at a time: no new request
// is accepted until the result of the last one is loaded.
//
// Reset restores the register defaults and clears the line memory. When the
// receiver stalls, the finished result waits in the output register and the
// next request is still accepted; its result is held back until the
// pending one is taken.
module line_follow_pd_steering_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_sensor_bits,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [8:0]                rsp_left_speed,
   output logic signed [8:0]                rsp_right_speed,
   output logic [3:0]                       rsp_track_state,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lfs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lfs_pkg::CSR_DATA_W-1:0]   csr_data
);

   lfs_pkg::cmd_type    cmd;
   lfs_pkg::status_type status;

   assign csr_ready = 1'b1;

   lfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lfs_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sensor_bits (req_sensor_bits),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_speed  (rsp_left_speed),
      .rsp_right_speed (rsp_right_speed),
      .rsp_track_state (rsp_track_state)
   );

endmodule
